// File: src/conserved_to_primitive_gas_macros.svh
// Assertion macros for the conserved-to-primitive gas block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef CONSERVED_TO_PRIMITIVE_GAS_MACROS_SVH
`define CONSERVED_TO_PRIMITIVE_GAS_MACROS_SVH

// implication checked outside reset
`define CTPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked during reset as well
`define CTPG_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/ctpg_pkg.sv
// Package for the conserved-to-primitive gas block: widths, latencies,
// register indexes and pipeline side-band types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctpg_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_LAT    = DIV_STEPS + 1;
  localparam int PIPE_LEN   = 3 + DIV_LAT + 3 + DIV_LAT;
  localparam int ADDR_W     = 4;

  localparam logic [1:0] REG_GAMMA = 2'd0;
  localparam logic [1:0] REG_COEFF_H = 2'd1;
  localparam logic [1:0] REG_COEFF_S = 2'd2;

  localparam logic [17:0] GAMMA_RST = 18'd109227;
  localparam logic [30:0] COEFF_RST = 31'd65536;
  localparam logic [17:0] ONE_Q = 18'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] e;
    logic [61:0]        rc;
    logic [2:0]         neg;
  } side_t;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [30:0] p;
  } prim_t;
endpackage
`default_nettype wire

// File: src/ctpg_div.sv
// Pipelined restoring divider: quo = min(floor(num / den), 2^32-1).
// One quotient bit per stage; uses ctpg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctpg_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [61:0] den,
  output logic [31:0]      quo
);
  import ctpg_pkg::*;

  logic [61:0] rem [0:DIV_STEPS];
  logic [31:0] low [0:DIV_STEPS];
  logic [31:0] q   [0:DIV_STEPS];
  logic [61:0] dd  [0:DIV_STEPS];
  logic        sat [0:DIV_STEPS];

  // quotient overflows 32 bits (or den is zero) when the top half reaches den
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {30'b0, num[63:32]};
      low[0] <= num[31:0];
      q[0]   <= '0;
      dd[0]  <= den;
      sat[0] <= ({30'b0, num[63:32]} >= den);
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem[i+1] <= ({rem[i], low[i][31]} >= {1'b0, dd[i]})
                    ? 62'({rem[i], low[i][31]} - {1'b0, dd[i]})
                    : {rem[i][60:0], low[i][31]};
        low[i+1] <= {low[i][30:0], 1'b0};
        q[i+1]   <= {q[i][30:0], ({rem[i], low[i][31]} >= {1'b0, dd[i]})};
        dd[i+1]  <= dd[i];
        sat[i+1] <= sat[i];
      end
    end
  end

  assign quo = sat[DIV_STEPS] ? '1 : q[DIV_STEPS];
endmodule
`default_nettype wire

// File: src/conserved_to_primitive_gas.sv
// Conserved-to-primitive conversion for an ideal gas, Q16.16. One cell per
// cycle is accepted. The pipeline is built from two 33-stage restoring divider
// pipelines (velocity and kinetic energy in parallel, then temperature) plus
// six arithmetic stages. The whole pipeline holds while an output is waiting
// and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "conserved_to_primitive_gas_macros.svh"
module conserved_to_primitive_gas (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // density, momentum_x, momentum_y, momentum_z, total_energy
  input  wire logic [159:0] s_tdata,
  // mode
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // vel_x, vel_y, vel_z, pressure, temperature, two zero bits
  output logic [159:0]      m_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [ctpg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ctpg_pkg::*;

  logic [17:0] gamma;
  logic [30:0] coeff_h, coeff_s;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma   <= GAMMA_RST;
      coeff_h <= COEFF_RST;
      coeff_s <= COEFF_RST;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_GAMMA:   gamma   <= pwdata[17:0];
        REG_COEFF_H: coeff_h <= pwdata[30:0];
        REG_COEFF_S: coeff_s <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_GAMMA:   prdata = {14'b0, gamma};
      REG_COEFF_H: prdata = {1'b0, coeff_h};
      REG_COEFF_S: prdata = {1'b0, coeff_s};
      default:     prdata = '0;
    endcase
  end

  // global advance: everything moves unless the output is held
  logic en;
  logic [PIPE_LEN-1:0] vld;
  assign en = !vld[PIPE_LEN-1] || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[PIPE_LEN-2:0], s_tvalid};
  end

  // S1: clamp density, magnitudes, species coefficient
  logic signed [31:0] den_in, mx_in, my_in, mz_in;
  logic [30:0] rho1, coeff1;
  logic [31:0] ax1, ay1, az1;
  logic [2:0]  neg1;
  logic signed [31:0] e1;

  assign den_in = s_tdata[31:0];
  assign mx_in  = s_tdata[63:32];
  assign my_in  = s_tdata[95:64];
  assign mz_in  = s_tdata[127:96];

  always_ff @(posedge clk) begin
    if (en) begin
      rho1   <= (den_in < 32'sd1) ? 31'd1 : den_in[30:0];
      coeff1 <= s_tuser ? coeff_s : coeff_h;
      ax1    <= mx_in[31] ? 32'(-mx_in) : mx_in;
      ay1    <= my_in[31] ? 32'(-my_in) : my_in;
      az1    <= mz_in[31] ? 32'(-mz_in) : mz_in;
      neg1   <= {mz_in[31], my_in[31], mx_in[31]};
      e1     <= s_tdata[159:128];
    end
  end

  // S2: squares and density times coefficient
  logic [63:0] sqx2, sqy2, sqz2;
  logic [61:0] rc2;
  logic [30:0] rho2;
  logic [31:0] ax2, ay2, az2;
  logic [2:0]  neg2;
  logic signed [31:0] e2;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= ax1 * ax1;
      sqy2 <= ay1 * ay1;
      sqz2 <= az1 * az1;
      rc2  <= rho1 * coeff1;
      rho2 <= rho1;
      ax2  <= ax1;
      ay2  <= ay1;
      az2  <= az1;
      neg2 <= neg1;
      e2   <= e1;
    end
  end

  // S3: sum of squares (each at most 2^62, no overflow)
  logic [63:0] sq3;
  logic [30:0] rho3;
  logic [31:0] ax3, ay3, az3;
  side_t       side3;

  always_ff @(posedge clk) begin
    if (en) begin
      sq3   <= sqx2 + sqy2 + sqz2;
      rho3  <= rho2;
      ax3   <= ax2;
      ay3   <= ay2;
      az3   <= az2;
      side3 <= '{e: e2, rc: rc2, neg: neg2};
    end
  end

  // first divider bank
  logic [31:0] qx, qy, qz, qke;
  logic [61:0] rho_d, rho2_d;
  assign rho_d  = {31'b0, rho3};
  assign rho2_d = {30'b0, rho3, 1'b0};

  ctpg_div u_div_x (.clk, .en, .num({16'b0, ax3, 16'b0}), .den(rho_d), .quo(qx));
  ctpg_div u_div_y (.clk, .en, .num({16'b0, ay3, 16'b0}), .den(rho_d), .quo(qy));
  ctpg_div u_div_z (.clk, .en, .num({16'b0, az3, 16'b0}), .den(rho_d), .quo(qz));
  ctpg_div u_div_ke (.clk, .en, .num(sq3), .den(rho2_d), .quo(qke));

  side_t side_d [0:DIV_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side3;
      for (int k = 1; k < DIV_LAT; k++) side_d[k] <= side_d[k-1];
    end
  end

  function automatic logic [31:0] sign_sat(input logic [31:0] q, input logic neg);
    if (!neg) return q[31] ? 32'h7FFF_FFFF : q;
    return q[31] ? 32'h8000_0000 : 32'(-q);
  endfunction

  // S4: internal energy and signed velocities
  side_t       sd;
  logic [30:0] eint4;
  logic [61:0] rc4, rc5, rc6;
  prim_t       pr4, pr5, pr6;

  assign sd = side_d[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      eint4 <= (sd.e[31] || (qke > {1'b0, sd.e[30:0]})) ? 31'd0
               : 31'(sd.e[30:0] - qke[30:0]);
      rc4   <= sd.rc;
      pr4   <= '{vx: sign_sat(qx, sd.neg[0]), vy: sign_sat(qy, sd.neg[1]),
                 vz: sign_sat(qz, sd.neg[2]), p: '0};
    end
  end

  // S5: (gamma - 1) * eint
  logic [17:0] gm1;
  logic [48:0] prod5;
  assign gm1 = (gamma > ONE_Q) ? 18'(gamma - ONE_Q) : 18'd0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod5 <= gm1 * eint4;
      rc5   <= rc4;
      pr5   <= pr4;
    end
  end

  // S6: scale, saturate, floor at one LSB
  logic [32:0] psh;
  logic [30:0] p_next;
  assign psh = prod5[48:FRAC_BITS];

  always_comb begin
    if (psh > 33'h0_7FFF_FFFF) p_next = 31'h7FFF_FFFF;
    else if (psh == 33'd0)     p_next = 31'd1;
    else                       p_next = psh[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc6 <= rc5;
      pr6 <= '{vx: pr5.vx, vy: pr5.vy, vz: pr5.vz, p: p_next};
    end
  end

  // temperature divider
  logic [31:0] qt;
  ctpg_div u_div_t (.clk, .en, .num({1'b0, pr6.p, 32'b0}), .den(rc6), .quo(qt));

  prim_t pr_d [0:DIV_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      pr_d[0] <= pr6;
      for (int k = 1; k < DIV_LAT; k++) pr_d[k] <= pr_d[k-1];
    end
  end

  prim_t po;
  logic [30:0] temp;
  assign po   = pr_d[DIV_LAT-1];
  assign temp = qt[31] ? 31'h7FFF_FFFF : qt[30:0];
  assign m_tdata = {2'b00, temp, po.p, po.vz, po.vy, po.vx};

  `CTPG_ASSERT_IMP(a_press_nonzero, m_tvalid, m_tdata[126:96] != 31'd0, "pressure is zero")
  `CTPG_ASSERT_IMP(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready), "ready mismatch")
  `CTPG_ASSERT_RST(a_reset_empty, $past(rst) && !rst, !m_tvalid, "valid after reset")
  `CTPG_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[159:158] == 2'b00, "pad bits set")
endmodule
`default_nettype wire

// File: sim/tb_conserved_to_primitive_gas.sv
// Testbench for conserved_to_primitive_gas: random and directed cells, APB register
// setup, scoreboard with an own fixed-point model. Depends on ctpg_pkg and the RTL.
`timescale 1ns / 1ps
module tb_conserved_to_primitive_gas;
  import ctpg_pkg::*;

  typedef struct {
    logic [31:0] vx, vy, vz;
    logic [30:0] p, t;
  } prim_res_t;

  class gas_scoreboard;
    logic [17:0] gam;
    logic [30:0] coef_h, coef_na;
    prim_res_t   pending[$];
    int          errors;

    function new();
      gam = GAMMA_RST;
      coef_h = COEFF_RST;
      coef_na = COEFF_RST;
      errors = 0;
    endfunction

    function logic [31:0] vel(longint m, longint rho);
      longint q;
      q = (m * 65536) / rho;
      if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
      if (q < -64'sh80000000) q = -64'sh80000000;
      return q[31:0];
    endfunction

    // floor(a << 32 / b), saturating
    function logic [30:0] temp_div(logic [63:0] a, logic [63:0] b);
      logic [63:0] q, r;
      if (b == 0) return 31'h7FFFFFFF;
      q = a / b;
      r = a % b;
      if (q > 64'h7FFFFFFF) return 31'h7FFFFFFF;
      for (int i = 0; i < 2 * FRAC_BITS; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= b) begin
          q++;
          r -= b;
        end
        if (q > 64'h7FFFFFFF) return 31'h7FFFFFFF;
      end
      return q[30:0];
    endfunction

    function void note_cell(logic mode, logic [159:0] d);
      prim_res_t r;
      longint rho, mx, my, mz, e, eint;
      logic [63:0] sq, ke, gm1, p, cf;
      rho = longint'($signed(d[31:0]));
      mx = longint'($signed(d[63:32]));
      my = longint'($signed(d[95:64]));
      mz = longint'($signed(d[127:96]));
      e = longint'($signed(d[159:128]));
      if (rho < 1) rho = 1;
      r.vx = vel(mx, rho);
      r.vy = vel(my, rho);
      r.vz = vel(mz, rho);
      sq = 64'(mx * mx) + 64'(my * my) + 64'(mz * mz);
      ke = sq / (2 * 64'(rho));
      eint = e - longint'(ke);
      if (eint < 0) eint = 0;
      gm1 = (gam > 18'(65536)) ? 64'(gam) - 65536 : 0;
      p = (gm1 * 64'(eint)) >> FRAC_BITS;
      if (p > 64'h7FFFFFFF) p = 64'h7FFFFFFF;
      if (p < 1) p = 1;
      r.p = p[30:0];
      cf = mode ? 64'(coef_na) : 64'(coef_h);
      r.t = temp_div(p, 64'(rho) * cf);
      pending.push_back(r);
    endfunction

    function void check_result(logic [159:0] d);
      prim_res_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (d[31:0] !== x.vx) begin
        $display("%0t: vel_x exp %h got %h", $time, x.vx, d[31:0]); errors++;
      end
      if (d[63:32] !== x.vy) begin
        $display("%0t: vel_y exp %h got %h", $time, x.vy, d[63:32]); errors++;
      end
      if (d[95:64] !== x.vz) begin
        $display("%0t: vel_z exp %h got %h", $time, x.vz, d[95:64]); errors++;
      end
      if (d[126:96] !== x.p) begin
        $display("%0t: pressure exp %h got %h", $time, x.p, d[126:96]); errors++;
      end
      if (d[157:127] !== x.t) begin
        $display("%0t: temperature exp %h got %h", $time, x.t, d[157:127]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
  logic [159:0] s_tdata = '0;
  logic s_tready, m_tvalid, pready;
  logic [159:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  int send_idle = 0, recv_idle = 0, hold_cycles = 0;
  longint cycles = 0;
  gas_scoreboard sb = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  conserved_to_primitive_gas u_dut (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_conserved_to_primitive_gas failed");
      $finish;
    end
  end

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_GAMMA:   sb.gam = val[17:0];
      REG_COEFF_H: sb.coef_h = val[30:0];
      REG_COEFF_S: sb.coef_na = val[30:0];
      default: ;
    endcase
  endtask

  task automatic send_cell(logic mode, logic [159:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= mode; s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_cell(mode, d);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h3FFFF);
      2: return -$urandom_range(0, 32'h3FFFF);
      3: return $urandom_range(0, 32'h7FFFFF);
      4: return {$urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF};
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // plausible cell (one in four is fully random): positive density, momentum small against energy
  function automatic logic [159:0] rnd_cell();
    logic [31:0] rho, e;
    if ($urandom_range(3) == 0)
      return {rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val()};
    rho = $urandom_range(32'h100, 32'h3FFFFFFF) >> $urandom_range(16);
    e = $urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(20);
    return {e, 32'($signed(rnd_val()) >>> 12), 32'($signed(rnd_val()) >>> 12),
            32'($signed(rnd_val()) >>> 12), rho + 1};
  endfunction

  task automatic random_phase(int n, int si, int ri);
    send_idle = si;
    recv_idle = ri;
    repeat (n) send_cell($urandom_range(1), rnd_cell());
  endtask

  initial begin
    logic [31:0] ext[6];
    ext = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h10000};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, zero/negative density, negative internal energy
    foreach (ext[i]) begin
      send_cell(i[0], {ext[i], ext[i], ext[i], ext[i], ext[i]});
      send_cell(!i[0], {ext[5 - i], ext[i], ~ext[i], ext[i], ext[(i + 1) % 6]});
    end
    send_cell(0, {32'h00010000, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h1});
    send_cell(1, {32'h00000001, 32'h0, 32'h0, 32'h00100000, 32'h00010000});
    drain();
    reg_write(REG_GAMMA, 32'h10000);  // gamma of one: pressure floor
    reg_write(REG_COEFF_H, 32'h1);
    reg_write(REG_COEFF_S, 32'h7FFFFFFF);
    send_cell(0, {32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h10000});
    send_cell(1, {32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h10000});
    drain();
    reg_write(REG_GAMMA, 32'h3FFFF);  // above range, also all-ones bits
    reg_write(REG_COEFF_H, 32'hFFFFFFFF);
    reg_write(REG_COEFF_S, 32'h0);
    random_phase(80, 29, 54);
    drain();
    reg_write(REG_GAMMA, 32'h30000);
    reg_write(REG_COEFF_H, 32'h10000 + $urandom_range(32'hFFFFF));
    reg_write(REG_COEFF_S, $urandom_range(1, 32'h7FFFFFFF));
    random_phase(200, 54, 29);
    drain();
    reg_write(REG_GAMMA, 32'h1AAAB);
    reg_write(REG_COEFF_H, 32'h10000);
    reg_write(REG_COEFF_S, 32'h40000);
    // pressure: long receiver hold while the sender keeps offering
    hold_cycles = 300;
    random_phase(120, 0, 0);
    random_phase(400, 0, 0);
    drain();
    if (sb.errors == 0)
      $display("tb_conserved_to_primitive_gas passed");
    else
      $display("tb_conserved_to_primitive_gas failed");
    $finish;
  end
endmodule
